>>> hw/rtl/vgci_pkg.sv
// shared constants and types for the voxel grid cluster index block
package vgci_pkg;

    localparam int MAX_BATCHES = 16;
    localparam int COORD_WIDTH = 32;
    localparam int BATCH_W     = 4;
    localparam int VSIZE_W     = 31;
    localparam int INDEX_W     = 64;
    // dividend width: three bits more than a coordinate, to hold a coordinate minus an origin
    localparam int DIV_W       = COORD_WIDTH + 3;

    typedef enum logic [1:0] {
        OP_CLEAR    = 2'd0,
        OP_ACCUM    = 2'd1,
        OP_CLASSIFY = 2'd2,
        OP_NONE     = 2'd3
    } op_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] low_x;
        logic signed [COORD_WIDTH-1:0] low_y;
        logic signed [COORD_WIDTH-1:0] low_z;
        logic signed [COORD_WIDTH-1:0] high_x;
        logic signed [COORD_WIDTH-1:0] high_y;
    } bbox_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } unit_ctl_t;

endpackage

>>> hw/rtl/voxel_grid_cluster_index.sv
// voxel grid cluster index: bounding box store, classify sequencer and result register
// clear and undefined ops finish in idle; accumulate reads the memory, then writes back
// a classify of an empty batch goes from the read straight to the result; otherwise it runs 8 divisions on the
// shared divider and 6 multiplies on the shared shift-add multiplier
// one beat at a time: in_stall stays high until the current beat is through
// reset: seen flags cleared, cell size 65536, bounding box memory left undefined
module voxel_grid_cluster_index
    import vgci_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [VSIZE_W-1:0]            cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    op,
    input  logic [BATCH_W-1:0]            batch,
    input  logic signed [COORD_WIDTH-1:0] x_coord,
    input  logic signed [COORD_WIDTH-1:0] y_coord,
    input  logic signed [COORD_WIDTH-1:0] z_coord,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [INDEX_W-1:0]     voxel_index,
    output logic                          batch_empty
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_LAUNCH,
        S_WAIT,
        S_OUT
    } state_t;

    // classify steps, in order
    localparam logic [3:0] ST_DIV_LX = 4'd0;
    localparam logic [3:0] ST_MUL_OX = 4'd1;
    localparam logic [3:0] ST_DIV_LY = 4'd2;
    localparam logic [3:0] ST_MUL_OY = 4'd3;
    localparam logic [3:0] ST_DIV_LZ = 4'd4;
    localparam logic [3:0] ST_MUL_OZ = 4'd5;
    localparam logic [3:0] ST_DIV_DX = 4'd6;
    localparam logic [3:0] ST_DIV_DY = 4'd7;
    localparam logic [3:0] ST_DIV_GX = 4'd8;
    localparam logic [3:0] ST_DIV_GY = 4'd9;
    localparam logic [3:0] ST_DIV_GZ = 4'd10;
    localparam logic [3:0] ST_MUL_T1 = 4'd11;
    localparam logic [3:0] ST_MUL_T2 = 4'd12;
    localparam logic [3:0] ST_MUL_T3 = 4'd13;

    state_t state_reg;
    logic [3:0] step_reg;

    // bounding box store, one entry per batch, registered read
    bbox_t mem [MAX_BATCHES];
    bbox_t rd_data_reg;
    logic  mem_we;
    bbox_t mem_wdata;

    logic [MAX_BATCHES-1:0] seen_reg;
    logic [VSIZE_W-1:0]     vsize_reg;
    logic [VSIZE_W-1:0]     vsize_eff;

    // captured input beat
    op_t                           op_reg;
    logic [BATCH_W-1:0]            batch_reg;
    logic signed [COORD_WIDTH-1:0] x_reg;
    logic signed [COORD_WIDTH-1:0] y_reg;
    logic signed [COORD_WIDTH-1:0] z_reg;

    // intermediate results, all kept at 64 bits and wrapping
    logic [INDEX_W-1:0] q_reg;
    logic [INDEX_W-1:0] ox_reg;
    logic [INDEX_W-1:0] oy_reg;
    logic [INDEX_W-1:0] oz_reg;
    logic [INDEX_W-1:0] dx_reg;
    logic [INDEX_W-1:0] dy_reg;
    logic [INDEX_W-1:0] gx_reg;
    logic [INDEX_W-1:0] gy_reg;
    logic [INDEX_W-1:0] gz_reg;
    logic [INDEX_W-1:0] t1_reg;
    logic [INDEX_W-1:0] t2_reg;

    logic                      out_valid_reg;
    logic signed [INDEX_W-1:0] index_reg;
    logic                      empty_reg;
    logic [INDEX_W-1:0]        index_next;
    logic                      empty_next;

    // unit hookup
    unit_ctl_t                div_ctl;
    unit_ctl_t                mul_ctl;
    logic signed [DIV_W-1:0]  div_dividend;
    logic signed [DIV_W-1:0]  div_quot;
    logic [INDEX_W-1:0]       div_q64;
    logic [INDEX_W-1:0]       div_src;
    logic [INDEX_W-1:0]       mul_a;
    logic [INDEX_W-1:0]       mul_b;
    logic [INDEX_W-1:0]       mul_p;
    logic                     step_is_div;
    logic                     unit_done;

    logic in_fire;
    logic out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign vsize_eff = (vsize_reg == '0) ? VSIZE_W'(1) : vsize_reg;

    // voxel size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vsize_reg <= VSIZE_W'(65536);
        end
        else if (cfg_we)
        begin
            vsize_reg <= cfg_wdata;
        end
    end

    // accumulate: first point seeds the box, later points widen it
    always_comb
    begin
        mem_wdata = rd_data_reg;
        if (!seen_reg[batch_reg])
        begin
            mem_wdata.low_x  = x_reg;
            mem_wdata.high_x = x_reg;
            mem_wdata.low_y  = y_reg;
            mem_wdata.high_y = y_reg;
            mem_wdata.low_z  = z_reg;
        end
        else
        begin
            if (x_reg < rd_data_reg.low_x)  mem_wdata.low_x  = x_reg;
            if (x_reg > rd_data_reg.high_x) mem_wdata.high_x = x_reg;
            if (y_reg < rd_data_reg.low_y)  mem_wdata.low_y  = y_reg;
            if (y_reg > rd_data_reg.high_y) mem_wdata.high_y = y_reg;
            if (z_reg < rd_data_reg.low_z)  mem_wdata.low_z  = z_reg;
        end
    end

    assign mem_we = (state_reg == S_READ) && (op_reg == OP_ACCUM);

    // the fsm never reads while a write is pending, so no forwarding is needed
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[batch_reg] <= mem_wdata;
        end
        if (in_fire)
        begin
            rd_data_reg <= mem[batch];
        end
    end

    // operand selection for the current classify step
    always_comb
    begin
        step_is_div = 1'b1;
        div_src     = '0;
        mul_a       = '0;
        mul_b       = '0;
        case (step_reg)
            ST_DIV_LX: div_src = INDEX_W'(rd_data_reg.low_x);
            ST_DIV_LY: div_src = INDEX_W'(rd_data_reg.low_y);
            ST_DIV_LZ: div_src = INDEX_W'(rd_data_reg.low_z);
            ST_DIV_DX: div_src = INDEX_W'(rd_data_reg.high_x) - ox_reg;
            ST_DIV_DY: div_src = INDEX_W'(rd_data_reg.high_y) - oy_reg;
            ST_DIV_GX: div_src = INDEX_W'(x_reg) - ox_reg;
            ST_DIV_GY: div_src = INDEX_W'(y_reg) - oy_reg;
            ST_DIV_GZ: div_src = INDEX_W'(z_reg) - oz_reg;
            ST_MUL_OX, ST_MUL_OY, ST_MUL_OZ:
            begin
                step_is_div = 1'b0;
                mul_a       = q_reg;
                mul_b       = INDEX_W'(vsize_eff);
            end
            ST_MUL_T1:
            begin
                step_is_div = 1'b0;
                mul_a       = dx_reg;
                mul_b       = gy_reg;
            end
            ST_MUL_T2:
            begin
                step_is_div = 1'b0;
                mul_a       = dx_reg;
                mul_b       = dy_reg;
            end
            ST_MUL_T3:
            begin
                step_is_div = 1'b0;
                mul_a       = t2_reg;
                mul_b       = gz_reg;
            end
            default:
            begin
                step_is_div = 1'b1;
            end
        endcase
    end

    // all dividends fit DIV_W bits signed, so the truncation is exact
    assign div_dividend  = div_src[DIV_W-1:0];
    assign div_ctl.start = (state_reg == S_LAUNCH) && step_is_div;
    assign mul_ctl.start = (state_reg == S_LAUNCH) && !step_is_div;
    assign div_q64       = INDEX_W'(div_quot);
    assign unit_done     = step_is_div ? div_ctl.done : mul_ctl.done;

    vgci_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_ctl.start),
        .dividend (div_dividend),
        .divisor  (vsize_eff),
        .busy     (div_ctl.busy),
        .done     (div_ctl.done),
        .quotient (div_quot)
    );

    vgci_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_ctl.start),
        .mcand   (mul_a),
        .mplier  (mul_b),
        .busy    (mul_ctl.busy),
        .done    (mul_ctl.done),
        .product (mul_p)
    );

    // final index: gx + dx*gy + dx*dy*gz, wrapping
    assign index_next = gx_reg + t1_reg + mul_p;
    assign empty_next = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // a waiting result reloads the register in S_OUT instead
            if (out_valid_reg && !out_stall && state_reg != S_OUT)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        op_reg    <= op_t'(op);
                        batch_reg <= batch;
                        x_reg     <= x_coord;
                        y_reg     <= y_coord;
                        z_reg     <= z_coord;
                        if (op_t'(op) == OP_CLEAR)
                        begin
                            seen_reg <= '0;
                        end
                        else if (op_t'(op) == OP_ACCUM || op_t'(op) == OP_CLASSIFY)
                        begin
                            state_reg <= S_READ;
                        end
                    end
                end
                S_READ:
                begin
                    step_reg <= '0;
                    if (op_reg == OP_ACCUM)
                    begin
                        seen_reg[batch_reg] <= 1'b1;
                        state_reg           <= S_IDLE;
                    end
                    else if (!seen_reg[batch_reg])
                    begin
                        index_reg <= '0;
                        empty_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_LAUNCH;
                    end
                end
                S_LAUNCH:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (unit_done)
                    begin
                        step_reg <= step_reg + 1'b1;
                        if (step_reg == ST_MUL_T3)
                        begin
                            state_reg <= S_OUT;
                        end
                        else if (step_reg > ST_MUL_T3)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_LAUNCH;
                        end
                        case (step_reg)
                            ST_DIV_LX, ST_DIV_LY, ST_DIV_LZ: q_reg <= div_q64;
                            ST_MUL_OX: ox_reg <= mul_p;
                            ST_MUL_OY: oy_reg <= mul_p;
                            ST_MUL_OZ: oz_reg <= mul_p;
                            ST_DIV_DX: dx_reg <= div_q64 + INDEX_W'(1);
                            ST_DIV_DY: dy_reg <= div_q64 + INDEX_W'(1);
                            ST_DIV_GX: gx_reg <= div_q64;
                            ST_DIV_GY: gy_reg <= div_q64;
                            ST_DIV_GZ: gz_reg <= div_q64;
                            ST_MUL_T1: t1_reg <= mul_p;
                            ST_MUL_T2: t2_reg <= mul_p;
                            ST_MUL_T3:
                            begin
                                index_reg <= index_next;
                                empty_reg <= empty_next;
                            end
                            default: ;
                        endcase
                    end
                end
                S_OUT:
                begin
                    // hand the finished result to the output register once it is free
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        voxel_index   <= index_reg;
                        batch_empty   <= empty_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    // an empty batch always reports a zero index
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && batch_empty) |-> (voxel_index == '0))
        else $error("empty batch result with nonzero index");

    // the two shared units never run at the same time
    a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
        !(div_ctl.busy && mul_ctl.busy))
        else $error("divider and multiplier busy together");

    // no unit runs while the block takes new beats
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (!div_ctl.busy && !mul_ctl.busy))
        else $error("arithmetic unit busy while idle");

    // an accumulate writes back in the cycle after its beat
    a_acc_write: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && op == OP_ACCUM) |=> mem_we)
        else $error("accumulate did not write back");
`endif

endmodule

>>> hw/rtl/vgci_div.sv
// iterative signed floor divider, one quotient bit per cycle
module vgci_div
    import vgci_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [DIV_W-1:0]  dividend,
    input  logic [VSIZE_W-1:0]       divisor,
    output logic                     busy,
    output logic                     done,
    output logic signed [DIV_W-1:0]  quotient
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0]   mag_reg;
    logic [VSIZE_W:0]   rem_reg;
    logic               neg_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic signed [DIV_W-1:0] quot_reg;

    logic [VSIZE_W+1:0] trial;
    logic [VSIZE_W+1:0] diff;
    logic               fits;
    logic [DIV_W-1:0]   abs_in;
    logic [DIV_W-1:0]   floor_q;

    assign trial   = {rem_reg, mag_reg[DIV_W-1]};
    assign diff    = trial - {2'b00, divisor};
    assign fits    = trial >= {2'b00, divisor};
    assign abs_in  = dividend[DIV_W-1] ? (~dividend + 1'b1) : dividend;
    assign floor_q = neg_reg ? (~mag_reg + 1'b1 - {{(DIV_W-1){1'b0}}, (rem_reg != '0)})
                             : mag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                mag_reg  <= abs_in;
                rem_reg  <= '0;
                neg_reg  <= dividend[DIV_W-1];
                cnt_reg  <= CNT_W'(DIV_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (cnt_reg != '0)
                begin
                    rem_reg <= fits ? diff[VSIZE_W:0] : trial[VSIZE_W:0];
                    mag_reg <= {mag_reg[DIV_W-2:0], fits};
                    cnt_reg <= cnt_reg - 1'b1;
                end
                else
                begin
                    quot_reg <= floor_q;
                    done_reg <= 1'b1;
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

>>> hw/rtl/vgci_mul.sv
// shift-add multiplier, product modulo 2^64, stops when the multiplier runs out of ones
module vgci_mul
    import vgci_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [INDEX_W-1:0] mcand,
    input  logic [INDEX_W-1:0] mplier,
    output logic               busy,
    output logic               done,
    output logic [INDEX_W-1:0] product
);

    logic [INDEX_W-1:0] a_reg;
    logic [INDEX_W-1:0] b_reg;
    logic [INDEX_W-1:0] acc_reg;
    logic               busy_reg;
    logic               done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                a_reg    <= mcand;
                b_reg    <= mplier;
                acc_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (b_reg != '0)
                begin
                    if (b_reg[0])
                    begin
                        acc_reg <= acc_reg + a_reg;
                    end
                    a_reg <= {a_reg[INDEX_W-2:0], 1'b0};
                    b_reg <= {1'b0, b_reg[INDEX_W-1:1]};
                end
                else
                begin
                    done_reg <= 1'b1;
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign busy    = busy_reg;
    assign done    = done_reg;
    assign product = acc_reg;

endmodule
